### rtl/pwrfs_pkg.sv
package pwrfs_pkg;

  localparam int unsigned FrameBytes   = 3;
  localparam int unsigned FrameIdxW    = $clog2(FrameBytes);
  localparam logic [7:0]  CrcPoly      = 8'h8C;
  localparam logic [7:0]  PreambleByte = 8'hAA;
  localparam logic [7:0]  StartByte    = 8'h0F;
  localparam int unsigned CfgDataW     = 10;
  localparam int unsigned CfgIdxW      = 3;

  typedef enum logic [0:0] {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEVICE_ADDRESS = 3'd0,
    REG_SLOT_MS        = 3'd1,
    REG_WARMUP_MS      = 3'd2,
    REG_GAP_MS         = 3'd3,
    REG_PREAMBLE_BYTES = 3'd4,
    REG_REPEAT_COUNT   = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WARMUP   = 3'd1,
    PH_PREAMBLE = 3'd2,
    PH_STARTB   = 3'd3,
    PH_DATA     = 3'd4,
    PH_STOP     = 3'd5,
    PH_GAP      = 3'd6
  } phase_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] button_code;
  } in_req_t;

  typedef struct packed {
    logic line_level;
    logic tx_enable;
    logic busy_res;
  } out_req_t;

  // reflected crc-8, one byte, lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] d;
    logic       fb;
    crc = crc_in;
    d   = data;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ d[0];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
      d = d >> 1;
    end
    return crc;
  endfunction

endpackage

### rtl/pwrfs_stream_if.sv
interface pwrfs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/pulse_width_remote_frame_sender.sv
// pulse-width on-off keyed remote frame sender
// in_if carries requests: a one millisecond tick (cmd = tick) or a start with a
// button code 1..4. a start while idle latches address, code and crc-8, raises
// tx_enable and busy, waits warmup_ms ticks, then sends the frame repeat_count
// times: preamble bytes of 0xaa, start byte 0x0f, three frame bytes msb first,
// a three slot stop pulse and gap_ms low ticks.
// every accepted request yields exactly one request on out_if with the line
// level, tx_enable and busy as they stand after that input.
// the output register is loaded in the cycle after an input is accepted. one
// request per cycle while out_if.ready is high; the whole update is one pass
// through the counter logic between the state registers and the output register.
// a stalled receiver holds the output register; a new input is still accepted
// in the cycle the output is taken, so no bubble appears while ready is high.
// reset (rst_ni low, asynchronous) returns to idle with the default register
// values; configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i,
// by the user only while the block is idle; the block does not enforce this.
module pulse_width_remote_frame_sender
  import pwrfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pwrfs_stream_if.sink        in_if,
  pwrfs_stream_if.source      out_if
);

  // configuration registers
  logic [7:0] device_address_q;
  logic [7:0] slot_ms_q;
  logic [9:0] warmup_ms_q;
  logic [9:0] gap_ms_q;
  logic [4:0] preamble_bytes_q;
  logic [3:0] repeat_count_q;
  // crc of the address byte, refreshed whenever the address is written
  logic [7:0] crc_addr_q;

  // sequencer state
  phase_e     phase_q, phase_d;
  logic [9:0] tick_count_q, tick_count_d;
  logic [1:0] bit_slot_q, bit_slot_d;
  logic [2:0] bit_index_q, bit_index_d;
  logic [4:0] byte_index_q, byte_index_d;
  logic [3:0] frames_left_q, frames_left_d;
  logic [7:0] frame_bytes_q [FrameBytes];
  logic       frame_we;

  // output register
  logic     out_valid_q, out_valid_d;
  out_req_t out_data_q, out_data_d;

  logic       in_ready;
  logic       accept;
  logic [9:0] tick_inc;
  logic [9:0] limit;
  logic [7:0] slot_len;
  logic [7:0] cur_byte;
  logic       cur_bit;
  logic       busy_d;
  logic       line_d;
  logic [FrameIdxW-1:0] frame_idx;

  assign in_ready    = !out_valid_q || out_if.ready;
  assign in_if.ready = in_ready;
  assign accept      = in_if.valid && in_ready;

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_data_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_address_q <= 8'd0;
      slot_ms_q        <= 8'd1;
      warmup_ms_q      <= 10'd500;
      gap_ms_q         <= 10'd100;
      preamble_bytes_q <= 5'd10;
      repeat_count_q   <= 4'd3;
      crc_addr_q       <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEVICE_ADDRESS: begin
          device_address_q <= cfg_data_i[7:0];
          crc_addr_q       <= crc8_byte(8'd0, cfg_data_i[7:0]);
        end
        REG_SLOT_MS:        slot_ms_q        <= cfg_data_i[7:0];
        REG_WARMUP_MS:      warmup_ms_q      <= cfg_data_i;
        REG_GAP_MS:         gap_ms_q         <= cfg_data_i;
        REG_PREAMBLE_BYTES: preamble_bytes_q <= cfg_data_i[4:0];
        REG_REPEAT_COUNT:   repeat_count_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // phase that a new frame starts in, given the frames still to send
  function automatic phase_e frame_phase(input logic [3:0] frames, input logic [4:0] pre);
    phase_e ph;
    if (frames == 4'd0) begin
      ph = PH_IDLE;
    end else if (pre == 5'd0) begin
      ph = PH_STARTB;
    end else begin
      ph = PH_PREAMBLE;
    end
    return ph;
  endfunction

  assign slot_len = (slot_ms_q == 8'd0) ? 8'd1 : slot_ms_q;
  assign tick_inc = tick_count_q + 10'd1;

  always_comb begin
    phase_d       = phase_q;
    tick_count_d  = tick_count_q;
    bit_slot_d    = bit_slot_q;
    bit_index_d   = bit_index_q;
    byte_index_d  = byte_index_q;
    frames_left_d = frames_left_q;
    frame_we      = 1'b0;
    limit         = {2'b00, slot_len};

    if (phase_q == PH_WARMUP) begin
      limit = warmup_ms_q;
    end else if (phase_q == PH_GAP) begin
      limit = gap_ms_q;
    end

    if (accept) begin
      if (in_if.payload.cmd == CMD_START) begin
        if (phase_q == PH_IDLE && in_if.payload.button_code >= 3'd1 &&
            in_if.payload.button_code <= 3'd4) begin
          frame_we      = 1'b1;
          frames_left_d = repeat_count_q;
          tick_count_d  = 10'd0;
          bit_slot_d    = 2'd0;
          bit_index_d   = 3'd0;
          byte_index_d  = 5'd0;
          if (warmup_ms_q == 10'd0) begin
            phase_d = frame_phase(repeat_count_q, preamble_bytes_q);
          end else begin
            phase_d = PH_WARMUP;
          end
        end
      end else if (phase_q != PH_IDLE) begin
        tick_count_d = tick_inc;
        if (tick_inc >= limit || tick_inc == 10'd0) begin
          tick_count_d = 10'd0;
          unique case (phase_q)
            PH_WARMUP: begin
              bit_slot_d   = 2'd0;
              bit_index_d  = 3'd0;
              byte_index_d = 5'd0;
              phase_d      = frame_phase(frames_left_q, preamble_bytes_q);
            end
            PH_PREAMBLE, PH_STARTB, PH_DATA: begin
              if (bit_slot_q < 2'd2) begin
                bit_slot_d = bit_slot_q + 2'd1;
              end else if (bit_index_q < 3'd7) begin
                bit_slot_d  = 2'd0;
                bit_index_d = bit_index_q + 3'd1;
              end else begin
                bit_slot_d  = 2'd0;
                bit_index_d = 3'd0;
                if (phase_q == PH_PREAMBLE) begin
                  byte_index_d = byte_index_q + 5'd1;
                  if (byte_index_d >= preamble_bytes_q || byte_index_d == 5'd0) begin
                    byte_index_d = 5'd0;
                    phase_d      = PH_STARTB;
                  end
                end else if (phase_q == PH_STARTB) begin
                  byte_index_d = 5'd0;
                  phase_d      = PH_DATA;
                end else begin
                  byte_index_d = byte_index_q + 5'd1;
                  if (byte_index_d >= 5'(FrameBytes)) begin
                    byte_index_d = 5'd0;
                    phase_d      = PH_STOP;
                  end
                end
              end
            end
            PH_STOP: begin
              if (bit_slot_q < 2'd2) begin
                bit_slot_d = bit_slot_q + 2'd1;
              end else begin
                bit_slot_d = 2'd0;
                if (gap_ms_q == 10'd0) begin
                  frames_left_d = (frames_left_q != 4'd0) ? frames_left_q - 4'd1 : 4'd0;
                  bit_index_d   = 3'd0;
                  byte_index_d  = 5'd0;
                  phase_d       = frame_phase(frames_left_d, preamble_bytes_q);
                end else begin
                  phase_d = PH_GAP;
                end
              end
            end
            PH_GAP: begin
              // end of frame: count it and start the next one or go idle
              frames_left_d = (frames_left_q != 4'd0) ? frames_left_q - 4'd1 : 4'd0;
              bit_slot_d    = 2'd0;
              bit_index_d   = 3'd0;
              byte_index_d  = 5'd0;
              phase_d       = frame_phase(frames_left_d, preamble_bytes_q);
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    end
  end

  // line level after the update; frame bytes are never read on the start itself
  assign frame_idx = (byte_index_d < 5'(FrameBytes)) ? byte_index_d[FrameIdxW-1:0] : '0;

  always_comb begin
    unique case (phase_d)
      PH_PREAMBLE: cur_byte = PreambleByte;
      PH_STARTB:   cur_byte = StartByte;
      default:     cur_byte = frame_bytes_q[frame_idx];
    endcase
  end

  assign cur_bit = cur_byte[~bit_index_d];
  assign busy_d  = (phase_d != PH_IDLE);

  always_comb begin
    unique case (phase_d)
      PH_PREAMBLE, PH_STARTB, PH_DATA:
        line_d = (bit_slot_d == 2'd0) || (bit_slot_d == 2'd1 && !cur_bit);
      PH_STOP: line_d = 1'b1;
      default: line_d = 1'b0;
    endcase
  end

  always_comb begin
    out_data_d.line_level = line_d;
    out_data_d.tx_enable  = busy_d;
    out_data_d.busy_res   = busy_d;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      tick_count_q  <= 10'd0;
      bit_slot_q    <= 2'd0;
      bit_index_q   <= 3'd0;
      byte_index_q  <= 5'd0;
      frames_left_q <= 4'd0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      tick_count_q  <= tick_count_d;
      bit_slot_q    <= bit_slot_d;
      bit_index_q   <= bit_index_d;
      byte_index_q  <= byte_index_d;
      frames_left_q <= frames_left_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // frame bytes and output payload carry no reset
  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_bytes_q[0] <= device_address_q;
      frame_bytes_q[1] <= {5'd0, in_if.payload.button_code};
      frame_bytes_q[2] <= crc8_byte(crc_addr_q, {5'd0, in_if.payload.button_code});
    end
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  // the slot counter of a bit or the stop pulse never reaches three
  a_bit_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_slot_q != 2'd3)
    else $error("bit slot out of range");

  // idle means every frame has been sent
  a_idle_no_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> frames_left_q == 4'd0)
    else $error("idle with frames left");

  // a result of an idle block keeps the line low
  a_idle_line_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.busy_res |-> !out_data_q.line_level)
    else $error("line high while idle");

  // an ignored start leaves the sequencer where it was
  a_busy_start_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_if.payload.cmd == CMD_START && phase_q != PH_IDLE
    |=> $stable(phase_q) && $stable(tick_count_q) && $stable(frames_left_q))
    else $error("start while busy changed state");

endmodule
